/* hw/rtl/chme_pkg.sv */
// Shared types and codes for the chained hash map engine.
package chme_pkg;

    localparam int NODES_DEF = 1024;

    localparam logic [2:0] ACT_LOOKUP  = 3'd0;
    localparam logic [2:0] ACT_INSERT  = 3'd1;
    localparam logic [2:0] ACT_UPDATE  = 3'd2;
    localparam logic [2:0] ACT_REPLACE = 3'd3;
    localparam logic [2:0] ACT_DELETE  = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;
    localparam logic [2:0] ACT_CLEAR   = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUP       = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        key_high;
        logic [31:0]        key_low;
        logic signed [31:0] value_in;
        logic [9:0]         node_slot;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [10:0]        used_count;
    } t_out_word;

endpackage

/* hw/rtl/chained_hash_map_engine.sv */
// Flow: the hash (multiply, 8 modulo steps of 4 bits, dispatch), the bucket head read (S_HEAD,
// S_WHEAD), a read and check per chain node, then write back and the result in S_FIN; clear adds S_CLR.
// Throughput: one word at a time; the next word is taken once the result is registered.
// The walk reads each chain node in S_WRD and checks it in S_WCHK before it moves to the next.
// Reset (synchronous, active low) starts a clearing pass over all bucket heads
// and node links; no word is accepted until it ends.
module chained_hash_map_engine
    import chme_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = $clog2(NODES + 1);
    localparam int MOD_STEP = 4;
    localparam int MOD_CYC  = 32 / MOD_STEP;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MUL   = 5'd1;
    localparam logic [4:0] S_MOD   = 5'd2;
    localparam logic [4:0] S_DISP  = 5'd3;
    localparam logic [4:0] S_CLR   = 5'd4;
    localparam logic [4:0] S_HEAD  = 5'd5;
    localparam logic [4:0] S_WHEAD = 5'd6;
    localparam logic [4:0] S_WRD   = 5'd7;
    localparam logic [4:0] S_WCHK  = 5'd8;
    localparam logic [4:0] S_DEL2  = 5'd9;
    localparam logic [4:0] S_AWAIT = 5'd10;
    localparam logic [4:0] S_ALLOC = 5'd11;
    localparam logic [4:0] S_ALINK = 5'd12;
    localparam logic [4:0] S_RWAIT = 5'd13;
    localparam logic [4:0] S_RCHK  = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;

    typedef struct packed {
        logic          busy;
        logic [PW-1:0] next;
    } t_link;

    logic [PW-1:0] m_head [NODES];
    t_link         m_link [NODES];
    logic [63:0]   m_key  [NODES];
    logic [31:0]   m_val  [NODES];

    logic [4:0]     r_state;
    t_in_word       r_req;
    logic [31:0]    r_prod;
    logic [PW:0]    r_rem;
    logic [2:0]     r_mcnt;
    logic [PW-1:0]  r_cur;
    logic [PW-1:0]  r_prev;
    logic [PW-1:0]  r_steps;
    logic [PW-1:0]  r_free;
    logic [PW-1:0]  r_occ;
    logic [PW-1:0]  r_ci;
    logic           r_silent;
    logic [1:0]     r_st;
    logic [31:0]    r_vo;
    logic           r_ovalid;
    t_out_word      r_out;
    logic [PW-1:0]  r_head_q;
    t_link          r_link_q;
    logic [63:0]    r_key_q;
    logic [31:0]    r_val_q;

    logic           in_fire;
    logic [16:0]    s1;
    logic [16:0]    s2;
    logic [PW:0]    rem_step;
    logic [31:0]    prod_step;
    logic [63:0]    req_key;
    logic           walk_miss;
    logic           walk_hit;
    logic           slot_ok;

    logic           head_we;
    logic [IW-1:0]  head_wa;
    logic [PW-1:0]  head_wd;
    logic           link_we;
    logic [IW-1:0]  link_wa;
    t_link          link_wd;
    logic           key_we;
    logic           val_we;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign s1 = 17'(r_req.key_high[31:16]) + 17'(r_req.key_high[15:0]);
    assign s2 = 17'(r_req.key_low[31:16]) + 17'(r_req.key_low[15:0]);
    assign req_key = {r_req.key_high, r_req.key_low};
    assign slot_ok = 32'(r_req.node_slot) < 32'(NODES);

    // Restoring modulo: shift in four product bits per cycle.
    always_comb begin
        rem_step  = r_rem;
        prod_step = r_prod;
        for (int k = 0; k < MOD_STEP; k++) begin
            rem_step  = {rem_step[PW-1:0], prod_step[31]};
            prod_step = {prod_step[30:0], 1'b0};
            if (rem_step >= (PW+1)'(NODES)) begin
                rem_step = rem_step - (PW+1)'(NODES);
            end
        end
    end

    assign walk_miss = (r_cur >= NIL) || (r_steps >= NIL);
    assign walk_hit  = !walk_miss && (r_key_q == req_key);

    // Memory write controls.
    always_comb begin
        head_we = 1'b0;
        head_wa = r_rem[IW-1:0];
        head_wd = r_link_q.next;
        link_we = 1'b0;
        link_wa = r_prev[IW-1:0];
        link_wd = '{busy: 1'b1, next: r_link_q.next};
        key_we  = 1'b0;
        val_we  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                head_we = 1'b1;
                head_wa = r_ci[IW-1:0];
                head_wd = NIL;
                link_we = 1'b1;
                link_wa = r_ci[IW-1:0];
                link_wd = '{busy: 1'b0, next: r_ci + PW'(1)};
            end
            S_WCHK: begin
                if (walk_hit && r_req.action == ACT_DELETE) begin
                    // unlink the hit node from its chain
                    if (r_prev == NIL) begin
                        head_we = 1'b1;
                    end else begin
                        link_we = 1'b1;
                    end
                end
                if (walk_hit && (r_req.action == ACT_UPDATE ||
                                 r_req.action == ACT_REPLACE)) begin
                    val_we = 1'b1;
                end
            end
            S_DEL2: begin
                link_we = 1'b1;
                link_wa = r_cur[IW-1:0];
                link_wd = '{busy: 1'b0, next: r_free};
            end
            S_ALLOC: begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                link_we = 1'b1;
                link_wa = r_cur[IW-1:0];
                link_wd = '{busy: 1'b1, next: NIL};
                if (r_prev == NIL) begin
                    head_we = 1'b1;
                    head_wd = r_cur;
                end
            end
            S_ALINK: begin
                link_we = 1'b1;
                link_wd = '{busy: 1'b1, next: r_cur};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[head_wa] <= head_wd;
        end
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        if (key_we) begin
            m_key[r_cur[IW-1:0]] <= req_key;
        end
        if (val_we) begin
            m_val[r_cur[IW-1:0]] <= r_req.value_in;
        end
        r_head_q <= m_head[r_rem[IW-1:0]];
        r_link_q <= m_link[r_cur[IW-1:0]];
        r_key_q  <= m_key[r_cur[IW-1:0]];
        r_val_q  <= m_val[r_cur[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ci     <= '0;
            r_silent <= 1'b1;
            r_ovalid <= 1'b0;
            r_free   <= '0;
            r_occ    <= '0;
        end else begin
            if (r_ovalid && i_out_ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req   <= i_in_data;
                        r_st    <= ST_OK;
                        r_vo    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 32'(34'(s1) * 34'(s2));
                    r_rem   <= '0;
                    r_mcnt  <= '0;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rem  <= rem_step;
                    r_prod <= prod_step;
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_mcnt == 3'(MOD_CYC - 1)) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_req.action)
                        ACT_CLEAR: begin
                            r_ci     <= '0;
                            r_silent <= 1'b0;
                            r_state  <= S_CLR;
                        end
                        ACT_READ: begin
                            if (slot_ok) begin
                                r_cur   <= PW'(r_req.node_slot);
                                r_state <= S_RWAIT;
                            end else begin
                                r_st    <= ST_NOT_FOUND;
                                r_state <= S_FIN;
                            end
                        end
                        ACT_INSERT: begin
                            if (r_free == NIL) begin
                                r_st    <= ST_FULL;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_HEAD;
                            end
                        end
                        ACT_LOOKUP, ACT_UPDATE, ACT_REPLACE, ACT_DELETE: begin
                            r_state <= S_HEAD;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_CLR: begin
                    r_ci <= r_ci + PW'(1);
                    if (r_ci == PW'(NODES - 1)) begin
                        r_free  <= '0;
                        r_occ   <= '0;
                        r_state <= r_silent ? S_IDLE : S_FIN;
                    end
                end
                S_HEAD: begin
                    r_state <= S_WHEAD;
                end
                S_WHEAD: begin
                    r_cur   <= r_head_q;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_state <= S_WRD;
                end
                S_WRD: begin
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (walk_hit) begin
                        r_state <= S_FIN;
                        case (r_req.action)
                            ACT_LOOKUP: r_vo <= r_val_q;
                            ACT_INSERT: r_st <= ST_DUP;
                            ACT_DELETE: begin
                                r_vo    <= r_val_q;
                                r_state <= S_DEL2;
                            end
                            default: begin
                            end
                        endcase
                    end else if (walk_miss) begin
                        r_state <= S_FIN;
                        if (r_req.action == ACT_INSERT || r_req.action == ACT_REPLACE) begin
                            if (r_free == NIL) begin
                                r_st <= ST_FULL;
                            end else begin
                                // take the free list head; r_prev holds the chain tail
                                r_cur   <= r_free;
                                r_state <= S_AWAIT;
                            end
                        end else begin
                            r_st <= ST_NOT_FOUND;
                        end
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q.next;
                        r_steps <= r_steps + PW'(1);
                        r_state <= S_WRD;
                    end
                end
                S_DEL2: begin
                    r_free  <= r_cur;
                    if (r_occ != '0) begin
                        r_occ <= r_occ - PW'(1);
                    end
                    r_state <= S_FIN;
                end
                S_AWAIT: begin
                    r_state <= S_ALLOC;
                end
                S_ALLOC: begin
                    r_free  <= r_link_q.next;
                    r_occ   <= r_occ + PW'(1);
                    r_state <= (r_prev == NIL) ? S_FIN : S_ALINK;
                end
                S_ALINK: begin
                    r_state <= S_FIN;
                end
                S_RWAIT: begin
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    if (r_link_q.busy) begin
                        r_vo <= r_val_q;
                    end else begin
                        r_st <= ST_NOT_FOUND;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid         <= 1'b1;
                        r_out.status     <= r_st;
                        r_out.value_out  <= r_vo;
                        r_out.used_count <= 11'(r_occ);
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= NIL)
        else $error("occupied count above node count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("ready while a word is in work");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (r_rem < (PW+1)'(NODES)))
        else $error("bucket index out of range");

endmodule
